### sv/b91e_pkg.sv
// ----------------------------------------------------------------------------
// b91e_pkg
// Shared types and constants of the base-91 stream encoder.
// ----------------------------------------------------------------------------
package b91e_pkg;

  localparam int BYTE_W      = 8;
  localparam int STORE_W     = 21;
  localparam int CNT_W       = 5;
  localparam int CHAR_W      = 7;
  localparam int SHORT_BITS  = 13;
  localparam int LONG_BITS   = 14;
  localparam int SHORT_MIN   = 88;    // a 13-bit value must exceed this
  localparam int FLUSH_MAX   = 90;    // leftover above this needs two digits
  localparam int FLUSH_ONE   = 7;     // more bits than this need two digits
  localparam int DIGIT_BASE  = 91;
  localparam int CHAR_OFFSET = 33;
  // floor(v / 91) == (v * RECIP) >> RECIP_SHIFT for every 14-bit v
  localparam int RECIP       = 11523;
  localparam int RECIP_SHIFT = 20;

  typedef struct packed {
    logic                  has_pair;  // a 13/14-bit value was taken
    logic [LONG_BITS-1:0]  val;
    logic [SHORT_BITS-1:0] rest;      // leftover bits on a flush
    logic [2:0]            n;         // characters this request yields
    logic                  fin;
  } b91e_job_t;

endpackage

### sv/b91e_msg_if.sv
// ----------------------------------------------------------------------------
// b91e_msg_if
// Message byte channel: valid/ready with one byte and an end flag.
// ----------------------------------------------------------------------------
interface b91e_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### sv/b91e_code_if.sv
// ----------------------------------------------------------------------------
// b91e_code_if
// Encoded character channel: valid/ready with one character and a last flag.
// ----------------------------------------------------------------------------
interface b91e_code_if;
  logic       valid;
  logic       ready;
  logic [6:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

### sv/base91_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// base91_stream_encoder_unit
// Base-91 style stream encoder: message bytes in, characters 33..123 out.
// ----------------------------------------------------------------------------
//  channel | role   | payload                 | per request
//  msg     | sink   | data_byte, final_byte   | one message byte
//  code    | source | code_char, last_char    | one encoded character
//
//  One character leaves the output register per cycle unless code stalls. A byte
//  yields two characters when it gives a pair, none when a non-final byte gives
//  none, and up to four for a final byte. The next byte is taken in the cycle that the
//  last character of the current one moves to the output register.
//  Reset (rst, synchronous) empties the accumulator and both registers.
//  A stall on code holds the character; msg is held off once the job waits.
// ----------------------------------------------------------------------------
module base91_stream_encoder_unit import b91e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b91e_msg_if.sink    msg,
  b91e_code_if.source code
);

  b91e_job_t           job, job_new;
  logic                job_valid;
  logic [1:0]          ptr;
  logic                emit, job_done, take, is_last, in_pair;
  logic [LONG_BITS-1:0] operand;
  logic [7:0]          quot;
  logic [6:0]          rem, digit;

  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;

  assign is_last  = ptr == 2'(job.n - 3'd1);
  assign emit     = job_valid && (!out_valid || code.ready);
  assign job_done = emit && is_last;
  assign msg.ready = !rst && (!job_valid || job_done);
  assign take     = msg.valid && msg.ready;

  b91e_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (msg.data_byte),
    .final_byte (msg.final_byte),
    .job        (job_new)
  );

  // pair digits first, then the flush digits; odd slots carry the quotient
  assign in_pair = job.has_pair && !ptr[1];
  assign operand = in_pair ? job.val : {1'b0, job.rest};

  b91e_digit u_digit (
    .value (operand),
    .quot  (quot),
    .rem   (rem)
  );

  assign digit = ptr[0] ? quot[6:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      ptr       <= '0;
    end else if (take) begin
      job_valid <= job_new.n != 3'd0;
      ptr       <= '0;
    end else if (emit) begin
      ptr <= ptr + 2'd1;
      if (is_last) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (code.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= digit + CHAR_W'(CHAR_OFFSET);
      out_last <= job.fin && is_last;
    end
  end

  assign code.valid     = out_valid;
  assign code.code_char = out_char;
  assign code.last_char = out_last;

endmodule

### sv/b91e_digit.sv
// ----------------------------------------------------------------------------
// b91e_digit
// Splits a 14-bit value into quotient and remainder by 91.
// ----------------------------------------------------------------------------
module b91e_digit import b91e_pkg::*; (
  input  logic [LONG_BITS-1:0] value,
  output logic [7:0]           quot,
  output logic [6:0]           rem
);

  localparam int PROD_W = 2 * LONG_BITS;

  logic [PROD_W-1:0] prod;
  logic [15:0]       back;

  assign prod = PROD_W'(value) * PROD_W'(RECIP);
  assign quot = prod[RECIP_SHIFT +: 8];
  assign back = 16'(quot) * 16'(DIGIT_BASE);
  assign rem  = 7'(16'(value) - back);

endmodule

### sv/b91e_packer.sv
// ----------------------------------------------------------------------------
// b91e_packer
// Bit accumulator: appends a byte, takes a 13/14-bit value, plans the flush.
// ----------------------------------------------------------------------------
module b91e_packer import b91e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              final_byte,
  output b91e_job_t         job
);

  logic [STORE_W-1:0] bit_store, bit_store_next;
  logic [CNT_W-1:0]   bit_count, bit_count_next;

  logic [CNT_W-1:0]   cnt_lim, cnt_add, cnt_sh;
  logic [STORE_W-1:0] stored, store_sh;
  logic               pair, big, two;

  always_comb begin
    cnt_lim = (bit_count > CNT_W'(SHORT_BITS)) ? CNT_W'(SHORT_BITS) : bit_count;
    stored  = bit_store | (STORE_W'(data_byte) << cnt_lim);
    cnt_add = cnt_lim + CNT_W'(BYTE_W);
    pair    = cnt_add > CNT_W'(SHORT_BITS);
    big     = stored[SHORT_BITS-1:0] > SHORT_BITS'(SHORT_MIN);

    store_sh = stored;
    cnt_sh   = cnt_add;
    if (pair) begin
      if (big) begin
        store_sh = stored >> SHORT_BITS;
        cnt_sh   = cnt_add - CNT_W'(SHORT_BITS);
      end else begin
        store_sh = stored >> LONG_BITS;
        cnt_sh   = cnt_add - CNT_W'(LONG_BITS);
      end
    end

    job.has_pair = pair;
    job.val      = big ? {1'b0, stored[SHORT_BITS-1:0]} : stored[LONG_BITS-1:0];
    job.rest     = store_sh[SHORT_BITS-1:0];
    job.fin      = final_byte;
    two = (cnt_sh > CNT_W'(FLUSH_ONE)) ||
          (store_sh[SHORT_BITS-1:0] > SHORT_BITS'(FLUSH_MAX));
    job.n = pair ? 3'd2 : 3'd0;
    if (final_byte && (cnt_sh != '0)) begin
      job.n = job.n + (two ? 3'd2 : 3'd1);
    end

    // drop everything once the message ends
    bit_store_next = final_byte ? '0 : store_sh;
    bit_count_next = final_byte ? '0 : cnt_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store <= '0;
      bit_count <= '0;
    end else if (take) begin
      bit_store <= bit_store_next;
      bit_count <= bit_count_next;
    end
  end

endmodule

### sv/b91e_checker.sv
// ----------------------------------------------------------------------------
// b91e_checker
// Port-level checks of the base-91 stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b91e_checker (
  input logic       clk,
  input logic       rst,
  input logic       msg_valid,
  input logic       msg_ready,
  input logic       final_byte,
  input logic       code_valid,
  input logic       code_ready,
  input logic [6:0] code_char,
  input logic       last_char
);

  // hold a stalled character
  a_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(code_char) && $stable(last_char))
    else $error("stalled character changed");

  a_reset: assert property (@(posedge clk) rst |=> !code_valid)
    else $error("character valid after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> code_char >= 7'd33 && code_char <= 7'd123)
    else $error("character outside alphabet");

  // expect a valid character on code after a final byte is taken
  a_final: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_ready && final_byte |-> ##2 code_valid)
    else $error("final byte gave no character");

endmodule

bind base91_stream_encoder_unit b91e_checker u_b91e_checker (
  .clk        (clk),
  .rst        (rst),
  .msg_valid  (msg.valid),
  .msg_ready  (msg.ready),
  .final_byte (msg.final_byte),
  .code_valid (code.valid),
  .code_ready (code.ready),
  .code_char  (code.code_char),
  .last_char  (code.last_char)
);

### dv/tb_base91_stream_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base91_stream_encoder_unit
// Drives message bytes into the base-91 encoder and checks every character
// and end-of-message flag against typed rows or a bit accumulator model.
// A short table of hand-picked bytes comes first, then random messages under
// several mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_base91_stream_encoder_unit;
  import b91e_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 112;
  localparam int N_DIR        = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } code_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              fin;
    bit                typed;   // expected characters given below
    int                n;
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
  } stim_row_t;

  logic clk;
  logic rst;

  b91e_msg_if  msg ();
  b91e_code_if code ();

  base91_stream_encoder_unit dut (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg),
    .code (code)
  );

  // Model state
  logic [STORE_W-1:0] acc;
  logic [CNT_W-1:0]   acc_bits;

  code_t pending_chars[$];
  code_t want;

  int errs          = 0;
  int chars_checked = 0;
  int msgs_closed   = 0;
  int bytes_sent    = 0;
  int long_takes    = 0;
  int one_flushes   = 0;
  int bare_finals   = 0;
  int cycle_cnt     = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_cnt      = 0;
  bit hold_req      = 0;
  bit hold_ack      = 0;

  stim_row_t dir_tab [N_DIR] = '{
    '{8'h00, 1'b1, 1'b1, 2, 7'd33,  7'd33},
    '{8'hFF, 1'b1, 1'b1, 2, 7'd106, 7'd35},
    '{8'h01, 1'b1, 1'b1, 2, 7'd34,  7'd33},
    '{8'h80, 1'b0, 1'b1, 0, 7'd0,   7'd0},
    '{8'h7F, 1'b1, 1'b0, 0, 7'd0,   7'd0},
    '{8'h00, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'h00, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'h00, 1'b1, 1'b0, 0, 7'd0,   7'd0},
    '{8'hFF, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'hFF, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'hFF, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'hFF, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'h00, 1'b1, 1'b0, 0, 7'd0,   7'd0},
    '{8'hFF, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'hFF, 1'b1, 1'b0, 0, 7'd0,   7'd0},
    '{8'h55, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'hAA, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'h3C, 1'b1, 1'b0, 0, 7'd0,   7'd0},
    '{8'h5A, 1'b0, 1'b0, 0, 7'd0,   7'd0},
    '{8'hC3, 1'b1, 1'b0, 0, 7'd0,   7'd0}
  };

  int idle_tab  [4] = '{0, 61, 0, 17};
  int stall_tab [4] = '{0, 0, 61, 17};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Append one byte to the accumulator and return the characters it yields.
  function automatic int encode_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                     output code_t chars [4]);
    logic [LONG_BITS-1:0]  val;
    logic [SHORT_BITS-1:0] rest;
    int                    k;
    k = 0;
    foreach (chars[i]) chars[i] = '0;
    if (acc_bits > SHORT_BITS) acc_bits = CNT_W'(SHORT_BITS);
    acc      = acc | (STORE_W'(b) << acc_bits);
    acc_bits = CNT_W'(acc_bits + BYTE_W);
    if (acc_bits > SHORT_BITS) begin
      if (acc[SHORT_BITS-1:0] > SHORT_MIN) begin
        val      = LONG_BITS'(acc[SHORT_BITS-1:0]);
        acc      = acc >> SHORT_BITS;
        acc_bits = CNT_W'(acc_bits - SHORT_BITS);
      end else begin
        val      = acc[LONG_BITS-1:0];
        acc      = acc >> LONG_BITS;
        acc_bits = CNT_W'(acc_bits - LONG_BITS);
        long_takes++;
      end
      chars[k].chr = CHAR_W'(val % DIGIT_BASE + CHAR_OFFSET);
      k++;
      chars[k].chr = CHAR_W'(val / DIGIT_BASE + CHAR_OFFSET);
      k++;
    end
    if (fin) begin
      if (acc_bits != 0) begin
        rest = acc[SHORT_BITS-1:0];
        chars[k].chr = CHAR_W'(rest % DIGIT_BASE + CHAR_OFFSET);
        k++;
        if (acc_bits > FLUSH_ONE || rest > FLUSH_MAX) begin
          chars[k].chr = CHAR_W'(rest / DIGIT_BASE + CHAR_OFFSET);
          k++;
        end else begin
          one_flushes++;
        end
      end else begin
        bare_finals++;
      end
      if (k > 0) chars[k-1].last = 1'b1;
      acc      = '0;
      acc_bits = '0;
    end
    return k;
  endfunction

  // Offer one request on msg, with random idle cycles first; leave valid high.
  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic fin);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      msg.valid      <= 1'b0;
      msg.data_byte  <= BYTE_W'($urandom);
      msg.final_byte <= 1'($urandom);
      @(posedge clk);
    end
    msg.valid      <= 1'b1;
    msg.data_byte  <= b;
    msg.final_byte <= fin;
    @(posedge clk);
    while (!msg.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic encode_and_offer(input logic [BYTE_W-1:0] b, input logic fin);
    code_t chars [4];
    int    n;
    n = encode_byte(b, fin, chars);
    for (int i = 0; i < n; i++) pending_chars.push_back(chars[i]);
    offer_byte(b, fin);
  endtask

  // Drop the request, then hold until every expected character has come.
  task automatic wait_drained();
    msg.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Lean toward zero and small bytes so short low values force 14-bit takes.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return BYTE_W'($urandom_range(0, 15));
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request from the sender.
  always @(posedge clk) begin
    if (rst) begin
      code.ready <= 1'b0;
      hold_cnt   <= 0;
    end else if (hold_cnt != 0) begin
      code.ready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (hold_req != hold_ack) begin
      code.ready <= 1'b0;
      hold_cnt   <= HOLD_LEN;
      hold_ack   <= hold_req;
    end else begin
      code.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && code.valid && code.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: code_char %0d last_char %0b",
               code.code_char, code.last_char);
        errs++;
      end else begin
        want = pending_chars.pop_front();
        if (code.code_char !== want.chr) begin
          $error("code_char: expected %0d, got %0d", want.chr, code.code_char);
          errs++;
        end
        if (code.last_char !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, code.last_char);
          errs++;
        end
        chars_checked++;
        if (code.last_char) msgs_closed++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int    sent_ph;
    int    len;
    code_t chars [4];
    rst             = 1'b1;
    msg.valid       = 1'b0;
    msg.data_byte   = '0;
    msg.final_byte  = 1'b0;
    acc             = '0;
    acc_bits        = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].typed) begin
        void'(encode_byte(dir_tab[i].data, dir_tab[i].fin, chars));
        if (dir_tab[i].n > 0)
          pending_chars.push_back('{dir_tab[i].c0, dir_tab[i].fin && dir_tab[i].n == 1});
        if (dir_tab[i].n > 1)
          pending_chars.push_back('{dir_tab[i].c1, dir_tab[i].fin});
        offer_byte(dir_tab[i].data, dir_tab[i].fin);
      end else begin
        encode_and_offer(dir_tab[i].data, dir_tab[i].fin);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      // Hold the sender until the encoder has flushed everything.
      wait_drained();
      snd_idle_pct  = idle_tab[ph];
      rcv_stall_pct <= stall_tab[ph];
      sent_ph = 0;
      while (sent_ph < PHASE_BYTES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        if (len > PHASE_BYTES - sent_ph) len = PHASE_BYTES - sent_ph;
        for (int j = 0; j < len; j++) begin
          if (ph == 0 && sent_ph == 40) hold_req <= ~hold_req;
          encode_and_offer(pick_byte(), j == len - 1);
          sent_ph++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d characters never arrived", pending_chars.size());
      errs++;
    end

    $display("Encoded %0d bytes; %0d characters checked, %0d messages closed.",
             bytes_sent, chars_checked, msgs_closed);
    $display("Saw %0d 14-bit takes, %0d one-character flushes, %0d finals with no leftover.",
             long_takes, one_flushes, bare_finals);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
sv/b91e_pkg.sv
sv/b91e_msg_if.sv
sv/b91e_code_if.sv
sv/b91e_digit.sv
sv/b91e_packer.sv
sv/base91_stream_encoder_unit.sv
sv/b91e_checker.sv
dv/tb_base91_stream_encoder_unit.sv
